>>> rtl/core/sxt_pkg.sv
// Shared constants and types of the s-expression tokenizer.
`default_nettype none

package sxt_pkg;

  localparam int MAX_SYMBOL = 32;
  localparam int SYM_AW     = $clog2(MAX_SYMBOL);
  localparam int SYM_LW     = $clog2(MAX_SYMBOL + 1);

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_BQUOTE  = 8'h60;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [3:0] {
    K_EOF    = 4'd0,
    K_BOOL   = 4'd1,
    K_NUM    = 4'd2,
    K_SYMCH  = 4'd3,
    K_OPEN   = 4'd4,
    K_CLOSE  = 4'd5,
    K_QUOTE  = 4'd6,
    K_QQ     = 4'd7,
    K_UNQ    = 4'd8,
    K_SPLICE = 4'd9
  } token_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRUNC = 2'd1,
    ERR_OVF   = 2'd2
  } err_code_e;

  typedef struct packed {
    logic              en;
    logic [SYM_AW-1:0] addr;
    logic [7:0]        data;
  } sym_wr_t;

  typedef struct packed {
    logic              en;
    logic [SYM_AW-1:0] addr;
  } sym_rd_t;

  typedef struct packed {
    logic is_bool;
    logic bool_val;
  } sym_head_t;

endpackage

`default_nettype wire

>>> rtl/core/sxt_symbol_store.sv
// Symbol character buffer with registered read and boolean head detection.
`default_nettype none

module sxt_symbol_store (
  input  logic              clk_i,
  input  sxt_pkg::sym_wr_t  wr_i,
  input  sxt_pkg::sym_rd_t  rd_i,
  output logic [7:0]        rdata_o,
  output sxt_pkg::sym_head_t head_o
);
  import sxt_pkg::*;

  logic [7:0] mem_q [MAX_SYMBOL];
  logic [7:0] rdata_q;
  logic [7:0] first_q;
  logic [7:0] second_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.addr == SYM_AW'(0)) begin
      first_q <= wr_i.data;
    end
    if (wr_i.en && wr_i.addr == SYM_AW'(1)) begin
      second_q <= wr_i.data;
    end
  end

  assign rdata_o         = rdata_q;
  assign head_o.is_bool  = (first_q == CH_HASH) && (second_q == CH_T || second_q == CH_F);
  assign head_o.bool_val = (second_q == CH_T);

endmodule

`default_nettype wire

>>> rtl/core/sexpr_tokenizer_core.sv
// S-expression tokenizer: byte stream in, token stream out.
// A byte is taken only in ST_IDLE, after the tokens of the last byte are sent; a digit
// inside a number then goes through the shared 38-bit adder (times ten, then add the digit).
// Other bytes then send the tokens they end or start; symbol characters go one by one
// through a buffer read, then the output register. Output stalls hold the sequencer.
// Reset (rst_ni low, asynchronous): idle lexer, empty accumulator and symbol, no output.
`default_nettype none

module sexpr_tokenizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  input  logic [0:0]  s_axis_tuser_i,   // [0] end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] number_value, [32] bool_value,
                                        // [40:33] symbol_char, [41] symbol_end,
                                        // [43:42] error_code, [47:44] zero
  output logic [3:0]  m_axis_tuser_o,   // [3:0] token_kind
  output logic        m_axis_tlast_o    // last
);
  import sxt_pkg::*;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_COMMA   = 5'b00100,
    MODE_NUMBER  = 5'b01000,
    MODE_SYMBOL  = 5'b10000
  } lex_mode_e;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL     = 8'b0000_0010,
    ST_ADD     = 8'b0000_0100,
    ST_PEND    = 8'b0000_1000,
    ST_SYM_RD  = 8'b0001_0000,
    ST_SYM_OUT = 8'b0010_0000,
    ST_ITOK    = 8'b0100_0000,
    ST_EOF     = 8'b1000_0000
  } state_e;

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic logic is_delim(input logic [7:0] ch);
    return is_blank(ch) || ch == CH_LPAREN || ch == CH_RPAREN || ch == CH_SEMI;
  endfunction

  function automatic state_e first_state(input logic p, input logic s,
                                         input logic i, input logic e);
    state_e st;
    if (p) st = ST_PEND;
    else if (s) st = ST_SYM_RD;
    else if (i) st = ST_ITOK;
    else if (e) st = ST_EOF;
    else st = ST_IDLE;
    return st;
  endfunction

  state_e            state_q, state_d;
  lex_mode_e         mode_q, mode_d;
  logic [31:0]       acc_q, acc_d;
  logic              ovf_q, ovf_d;
  logic [SYM_LW-1:0] len_q, len_d;
  logic              trunc_q, trunc_d;
  logic              itok_q, itok_d;
  token_kind_e       itok_kind_q, itok_kind_d;
  logic              eof_q, eof_d;
  logic [SYM_AW-1:0] idx_q, idx_d;

  token_kind_e       pend_kind_q, pend_kind_d;
  logic [31:0]       pend_num_q, pend_num_d;
  logic [1:0]        pend_err_q, pend_err_d;
  logic              pend_bool_q, pend_bool_d;
  logic [SYM_LW-1:0] flen_q, flen_d;
  logic              ftrunc_q, ftrunc_d;
  logic [7:0]        c_q, c_d;
  logic [37:0]       sum_q, sum_d;

  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic [3:0]  m_user_q;
  logic        m_last_q;

  logic        accept;
  logic        out_free;
  logic        out_load;
  token_kind_e out_kind;
  logic [31:0] out_num;
  logic        out_bool;
  logic [7:0]  out_char;
  logic        out_end;
  logic [1:0]  out_err;
  logic        out_last;

  logic [7:0]  in_c;
  logic        in_eof;

  logic        ib_tok_v;
  token_kind_e ib_kind;
  lex_mode_e   ib_mode;
  logic        ib_num;
  logic        ib_sym;

  logic        fl_pend;
  token_kind_e fl_kind;
  logic [1:0]  fl_err;
  logic        fl_sym;

  logic        do_flush;
  logic        do_ib;
  logic        do_splice;
  logic        fold_go;
  logic        pend_n;
  logic        sym_n;

  logic signed [37:0] alu_a;
  logic signed [37:0] alu_b;
  logic signed [37:0] alu_sum;
  logic [8:0]         digit_off;
  logic               sum_ovf;
  logic               sym_last;

  sym_wr_t   sym_wr;
  sym_rd_t   sym_rd;
  logic [7:0] sym_rdata;
  sym_head_t  sym_head;

  sxt_symbol_store u_store (
    .clk_i   (clk_i),
    .wr_i    (sym_wr),
    .rd_i    (sym_rd),
    .rdata_o (sym_rdata),
    .head_o  (sym_head)
  );

  assign in_c     = s_axis_tdata_i;
  assign in_eof   = s_axis_tuser_i[0];
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // shared adder: times ten as two shifted copies, then the digit offset
  assign alu_sum   = alu_a + alu_b;
  assign digit_off = {1'b0, c_q} - 9'd48;
  assign sum_ovf   = alu_sum[37] || (|alu_sum[36:32]);
  assign sym_last  = (SYM_LW'(idx_q) + SYM_LW'(1)) == flen_q;

  // start-of-token decode
  always_comb begin
    ib_tok_v = 1'b0;
    ib_kind  = K_OPEN;
    ib_mode  = MODE_IDLE;
    ib_num   = 1'b0;
    ib_sym   = 1'b0;
    if (is_blank(in_c)) begin
      ib_mode = MODE_IDLE;
    end else if (in_c == CH_SEMI) begin
      ib_mode = MODE_COMMENT;
    end else if (in_c == CH_LPAREN) begin
      ib_tok_v = 1'b1;
      ib_kind  = K_OPEN;
    end else if (in_c == CH_RPAREN) begin
      ib_tok_v = 1'b1;
      ib_kind  = K_CLOSE;
    end else if (in_c == CH_QUOTE) begin
      ib_tok_v = 1'b1;
      ib_kind  = K_QUOTE;
    end else if (in_c == CH_BQUOTE) begin
      ib_tok_v = 1'b1;
      ib_kind  = K_QQ;
    end else if (in_c == CH_COMMA) begin
      ib_mode = MODE_COMMA;
    end else if (in_c >= CH_ZERO && in_c <= CH_NINE) begin
      ib_mode = MODE_NUMBER;
      ib_num  = 1'b1;
    end else begin
      ib_mode = MODE_SYMBOL;
      ib_sym  = 1'b1;
    end
  end

  // pending token of the current mode
  always_comb begin
    fl_pend = 1'b0;
    fl_kind = K_NUM;
    fl_err  = ERR_NONE;
    fl_sym  = 1'b0;
    unique case (mode_q)
      MODE_NUMBER: begin
        fl_pend = 1'b1;
        fl_kind = K_NUM;
        fl_err  = ovf_q ? ERR_OVF : ERR_NONE;
      end
      MODE_COMMA: begin
        fl_pend = 1'b1;
        fl_kind = K_UNQ;
      end
      MODE_SYMBOL: begin
        if (!trunc_q && len_q == SYM_LW'(2) && sym_head.is_bool) begin
          fl_pend = 1'b1;
          fl_kind = K_BOOL;
        end else begin
          fl_sym = 1'b1;
        end
      end
      MODE_IDLE, MODE_COMMENT: begin
        fl_pend = 1'b0;
      end
      default: begin
        fl_pend = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    len_d       = len_q;
    trunc_d     = trunc_q;
    itok_d      = itok_q;
    itok_kind_d = itok_kind_q;
    eof_d       = eof_q;
    idx_d       = idx_q;
    pend_kind_d = pend_kind_q;
    pend_num_d  = pend_num_q;
    pend_err_d  = pend_err_q;
    pend_bool_d = pend_bool_q;
    flen_d      = flen_q;
    ftrunc_d    = ftrunc_q;
    c_d         = c_q;
    sum_d       = sum_q;
    alu_a       = '0;
    alu_b       = '0;
    sym_wr      = '0;
    sym_rd      = '0;
    out_load    = 1'b0;
    out_kind    = K_EOF;
    out_num     = '0;
    out_bool    = 1'b0;
    out_char    = '0;
    out_end     = 1'b0;
    out_err     = ERR_NONE;
    out_last    = 1'b0;
    do_flush    = 1'b0;
    do_ib       = 1'b0;
    do_splice   = 1'b0;
    fold_go     = 1'b0;
    pend_n      = 1'b0;
    sym_n       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          c_d    = in_c;
          itok_d = 1'b0;
          eof_d  = 1'b0;
          idx_d  = '0;
          if (in_eof) begin
            do_flush = 1'b1;
            eof_d    = 1'b1;
          end else begin
            unique case (mode_q)
              MODE_COMMENT: begin
                if (in_c == CH_NL) mode_d = MODE_IDLE;
              end
              MODE_COMMA: begin
                if (in_c == CH_AT) begin
                  do_splice = 1'b1;
                  mode_d    = MODE_IDLE;
                end else begin
                  do_flush = 1'b1;
                  do_ib    = 1'b1;
                end
              end
              MODE_NUMBER: begin
                if (is_delim(in_c)) begin
                  do_flush = 1'b1;
                  do_ib    = 1'b1;
                end else begin
                  fold_go = 1'b1;
                end
              end
              MODE_SYMBOL: begin
                if (is_delim(in_c)) begin
                  do_flush = 1'b1;
                  do_ib    = 1'b1;
                end else if (len_q < SYM_LW'(MAX_SYMBOL)) begin
                  sym_wr.en   = 1'b1;
                  sym_wr.addr = len_q[SYM_AW-1:0];
                  sym_wr.data = in_c;
                  len_d       = len_q + SYM_LW'(1);
                end else begin
                  trunc_d = 1'b1;
                end
              end
              default: begin
                do_ib = 1'b1;
              end
            endcase
          end

          if (do_flush) begin
            pend_n      = fl_pend;
            sym_n       = fl_sym;
            pend_kind_d = fl_kind;
            pend_num_d  = acc_q;
            pend_err_d  = fl_err;
            pend_bool_d = sym_head.bool_val;
            flen_d      = len_q;
            ftrunc_d    = trunc_q;
            mode_d      = MODE_IDLE;
            acc_d       = '0;
            ovf_d       = 1'b0;
            len_d       = '0;
            trunc_d     = 1'b0;
          end
          if (do_splice) begin
            pend_n      = 1'b1;
            pend_kind_d = K_SPLICE;
            pend_err_d  = ERR_NONE;
          end
          if (do_ib) begin
            mode_d      = ib_mode;
            itok_d      = ib_tok_v;
            itok_kind_d = ib_kind;
            if (ib_num) begin
              acc_d = {28'd0, in_c[3:0]};
              ovf_d = 1'b0;
            end
            if (ib_sym) begin
              sym_wr.en   = 1'b1;
              sym_wr.addr = '0;
              sym_wr.data = in_c;
              len_d       = SYM_LW'(1);
              trunc_d     = 1'b0;
            end
          end

          if (fold_go) state_d = ST_MUL;
          else state_d = first_state(pend_n, sym_n, itok_d, eof_d);
        end
      end
      ST_MUL: begin
        alu_a   = {3'd0, acc_q, 3'd0};
        alu_b   = {5'd0, acc_q, 1'b0};
        sum_d   = alu_sum;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        alu_a   = sum_q;
        alu_b   = {{29{digit_off[8]}}, digit_off};
        acc_d   = alu_sum[31:0];
        ovf_d   = ovf_q | sum_ovf;
        state_d = ST_IDLE;
      end
      ST_PEND: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = pend_kind_q;
          out_num  = (pend_kind_q == K_NUM) ? pend_num_q : '0;
          out_bool = (pend_kind_q == K_BOOL) && pend_bool_q;
          out_err  = pend_err_q;
          out_last = !itok_q && !eof_q;
          state_d  = first_state(1'b0, 1'b0, itok_q, eof_q);
        end
      end
      ST_SYM_RD: begin
        sym_rd.en   = 1'b1;
        sym_rd.addr = idx_q;
        state_d     = ST_SYM_OUT;
      end
      ST_SYM_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = K_SYMCH;
          out_char = sym_rdata;
          out_end  = sym_last;
          out_err  = ftrunc_q ? ERR_TRUNC : ERR_NONE;
          out_last = sym_last && !itok_q && !eof_q;
          if (sym_last) begin
            idx_d   = '0;
            state_d = first_state(1'b0, 1'b0, itok_q, eof_q);
          end else begin
            idx_d   = idx_q + SYM_AW'(1);
            state_d = ST_SYM_RD;
          end
        end
      end
      ST_ITOK: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = itok_kind_q;
          out_last = !eof_q;
          state_d  = eof_q ? ST_EOF : ST_IDLE;
        end
      end
      ST_EOF: begin
        if (out_free) begin
          out_load = 1'b1;
          out_kind = K_EOF;
          out_last = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_IDLE;
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      len_q     <= '0;
      trunc_q   <= 1'b0;
      itok_q    <= 1'b0;
      eof_q     <= 1'b0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      len_q   <= len_d;
      trunc_q <= trunc_d;
      itok_q  <= itok_d;
      eof_q   <= eof_d;
      idx_q   <= idx_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    itok_kind_q <= itok_kind_d;
    pend_kind_q <= pend_kind_d;
    pend_num_q  <= pend_num_d;
    pend_err_q  <= pend_err_d;
    pend_bool_q <= pend_bool_d;
    flen_q      <= flen_d;
    ftrunc_q    <= ftrunc_d;
    c_q         <= c_d;
    sum_q       <= sum_d;
    if (out_load) begin
      m_data_q <= {4'd0, out_err, out_end, out_char, out_bool, out_num};
      m_user_q <= out_kind;
      m_last_q <= out_last;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= SYM_LW'(MAX_SYMBOL))
    else $error("symbol length beyond buffer");

  a_sym_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SYM_OUT |-> SYM_LW'(idx_q) < flen_q)
    else $error("symbol read index past flushed length");

  a_kind_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_user_q <= K_SPLICE)
    else $error("token kind out of range");

  a_eof_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_eof |=> mode_q == MODE_IDLE && len_q == '0 && acc_q == '0 && !ovf_q)
    else $error("end of input left lexer state");

  a_eof_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_kind == K_EOF |-> out_last)
    else $error("eof token not marked last");

endmodule

`default_nettype wire
